/* sv/lzss_pkg.sv */
// shared types and constants for the lzss stream decoder
`default_nettype none

package lzss_pkg;

    // ring window
    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW   = $clog2(WIN_DEPTH);
    localparam int FILL_W   = WIN_AW + 1;
    localparam logic [WIN_AW-1:0] WP_START = WIN_AW'(12'hFEE);

    // produced byte count and configured length
    localparam int LEN_W = 24;

    // match length code is length minus three, run counter covers 3..18
    localparam int LCODE_W   = 4;
    localparam int LEN_BIAS  = 3;
    localparam int RUN_MAX   = (1 << LCODE_W) - 1 + LEN_BIAS;
    localparam int RUN_W     = $clog2(RUN_MAX + 1);

    // token flag shift register: eight flag bits below a marker one
    localparam int FLAG_W = 9;

    // command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LIT,
        PH_MLOW,
        PH_MHIGH
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LIT,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        logic                clear;
        cmd_kind_t           kind;
        logic [7:0]          data;
        logic [WIN_AW-1:0]   pos;
        logic [LCODE_W-1:0]  len_code;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/lzss_front.sv */
// front end: parses flag and match bytes into window commands
`default_nettype none

module lzss_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_in_byte,
    input  wire logic             s_new_stream,
    input  wire logic             fifo_full,
    output logic                  push,
    output lzss_pkg::cmd_t        push_cmd
);

    lzss_pkg::phase_t                  phase_reg, phase_next;
    logic [lzss_pkg::FLAG_W-1:0]       flags_reg, flags_next;
    logic [7:0]                        low_reg, low_next;

    lzss_pkg::phase_t                  phase_cur;
    logic [lzss_pkg::FLAG_W-1:0]       flags_cur;
    logic [lzss_pkg::FLAG_W-1:0]       tok;
    logic                              pick;
    logic                              accept;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        // new stream restarts parsing before this byte
        phase_cur = s_new_stream ? lzss_pkg::PH_FLAG : phase_reg;
        flags_cur = s_new_stream ? '0 : flags_reg;

        tok        = {1'b0, flags_cur[lzss_pkg::FLAG_W-1:1]};
        pick       = 1'b1;
        low_next   = low_reg;
        phase_next = phase_cur;

        push_cmd          = '0;
        push_cmd.clear    = s_new_stream;
        push_cmd.kind     = lzss_pkg::CMD_NONE;
        push_cmd.data     = s_in_byte;
        push_cmd.pos      = {s_in_byte[7:4], low_reg};
        push_cmd.len_code = s_in_byte[3:0];

        unique case (phase_cur)
            lzss_pkg::PH_FLAG: begin
                tok = {1'b1, s_in_byte};
            end
            lzss_pkg::PH_LIT: begin
                push_cmd.kind = lzss_pkg::CMD_LIT;
            end
            lzss_pkg::PH_MLOW: begin
                low_next   = s_in_byte;
                tok        = flags_cur;
                pick       = 1'b0;
                phase_next = lzss_pkg::PH_MHIGH;
            end
            lzss_pkg::PH_MHIGH: begin
                push_cmd.kind = lzss_pkg::CMD_MATCH;
            end
            default: begin
                tok = flags_cur;
            end
        endcase

        flags_next = tok;
        if (pick) begin
            if (tok <= lzss_pkg::FLAG_W'(1)) begin
                phase_next = lzss_pkg::PH_FLAG;
            end else if (tok[0]) begin
                phase_next = lzss_pkg::PH_LIT;
            end else begin
                phase_next = lzss_pkg::PH_MLOW;
            end
        end

        push = accept && ((push_cmd.kind != lzss_pkg::CMD_NONE) || s_new_stream);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lzss_pkg::PH_FLAG;
            flags_reg <= '0;
            low_reg   <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            low_reg   <= low_next;
        end
    end

    // a match command only follows a low byte
    a_match_after_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_cmd.kind == lzss_pkg::CMD_MATCH) |-> (phase_reg == lzss_pkg::PH_MHIGH))
        else $error("match issued outside high byte phase");

    // flag register never empty while a token is expected
    a_flag_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lzss_pkg::PH_LIT || phase_reg == lzss_pkg::PH_MLOW)
            |-> (flags_reg > lzss_pkg::FLAG_W'(1)))
        else $error("token phase with no flag bits left");

    // low byte phase always moves to high byte phase
    a_low_to_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_new_stream && phase_reg == lzss_pkg::PH_MLOW)
            |=> (phase_reg == lzss_pkg::PH_MHIGH))
        else $error("low byte not followed by high byte phase");

endmodule

`default_nettype wire

/* sv/lzss_fifo.sv */
// short command queue between front and back
`default_nettype none

module lzss_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lzss_pkg::cmd_t  push_cmd,
    input  wire logic            pop,
    output lzss_pkg::cmd_t       pop_cmd,
    output logic                 full,
    output logic                 not_empty
);

    lzss_pkg::cmd_t                  fifo_mem [lzss_pkg::FIFO_DEPTH];
    logic [lzss_pkg::FIFO_AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [lzss_pkg::FIFO_CW-1:0]    count_reg;
    logic                            do_push, do_pop;

    assign full      = (count_reg == lzss_pkg::FIFO_CW'(lzss_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == lzss_pkg::FIFO_AW'(lzss_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == lzss_pkg::FIFO_AW'(lzss_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            fifo_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* sv/lzss_back.sv */
// back end: window memory, match copy, length tracking and output register
`default_nettype none

module lzss_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [lzss_pkg::LEN_W-1:0]    cfg_wdata,
    input  wire logic                          cmd_valid,
    input  wire lzss_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_last,
    output logic                               m_done_res
);

    logic [7:0]                     win_mem [lzss_pkg::WIN_DEPTH];

    logic [lzss_pkg::LEN_W-1:0]     len_reg;
    logic [lzss_pkg::WIN_AW-1:0]    wp_reg;
    logic [lzss_pkg::FILL_W-1:0]    fill_reg;
    logic [lzss_pkg::LEN_W-1:0]     prod_reg;
    logic                           fin_reg;
    logic [lzss_pkg::RUN_W-1:0]     rem_reg;
    logic [lzss_pkg::WIN_AW-1:0]    rd_addr_reg;

    // execute stage: one byte waiting to be written and emitted
    logic                           e_valid_reg;
    logic [7:0]                     rdata_reg;
    logic                           e_fwd_reg;
    logic [7:0]                     e_fwd_data_reg;
    logic                           e_vld_reg;
    logic                           e_last_reg;

    logic                           m_valid_reg;
    logic [7:0]                     m_byte_reg;
    logic                           m_last_reg;
    logic                           m_done_reg;

    logic                           e_adv;
    logic [lzss_pkg::LEN_W-1:0]     prod_inc;
    logic                           done_now;
    logic [7:0]                     d_cur;
    logic                           fin_eff;
    logic                           slot_free;
    logic                           take;
    logic                           issue;
    logic [lzss_pkg::WIN_AW-1:0]    rd_off;
    logic                           rd_in_fill;

    assign e_adv     = e_valid_reg && (!m_valid_reg || m_ready);
    assign prod_inc  = prod_reg + 1'b1;
    assign done_now  = (prod_inc >= len_reg);
    assign d_cur     = e_fwd_reg ? e_fwd_data_reg : (e_vld_reg ? rdata_reg : 8'h00);
    assign fin_eff   = fin_reg || (e_adv && done_now);
    assign slot_free = !e_valid_reg || e_adv;
    assign cmd_pop   = cmd_valid && (rem_reg == '0) && slot_free;
    assign take      = cmd_pop && (cmd.clear || !fin_eff);
    assign issue     = (rem_reg != '0) && slot_free && !(e_adv && done_now);

    // entries outside the span written since the last clear read as zero
    assign rd_off     = rd_addr_reg - lzss_pkg::WP_START;
    assign rd_in_fill = ({1'b0, rd_off} < fill_reg);

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;
    assign m_done_res = m_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= lzss_pkg::LEN_W'(1);
            wp_reg      <= lzss_pkg::WP_START;
            fill_reg    <= '0;
            prod_reg    <= '0;
            fin_reg     <= 1'b0;
            rem_reg     <= '0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                len_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (e_adv) begin
                m_valid_reg <= 1'b1;
                wp_reg      <= wp_reg + 1'b1;
                prod_reg    <= prod_inc;
                if (fill_reg != lzss_pkg::FILL_W'(lzss_pkg::WIN_DEPTH)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (done_now) begin
                    fin_reg <= 1'b1;
                    rem_reg <= '0;
                end
            end
            if (issue) begin
                rem_reg <= rem_reg - 1'b1;
            end
            if (issue || (take && cmd.kind == lzss_pkg::CMD_LIT)) begin
                e_valid_reg <= 1'b1;
            end else if (e_adv) begin
                e_valid_reg <= 1'b0;
            end
            // a clear lands after any byte leaving this cycle
            if (take) begin
                if (cmd.clear) begin
                    wp_reg   <= lzss_pkg::WP_START;
                    fill_reg <= '0;
                    prod_reg <= '0;
                    fin_reg  <= 1'b0;
                end
                if (cmd.kind == lzss_pkg::CMD_MATCH) begin
                    rem_reg <= lzss_pkg::RUN_W'(cmd.len_code)
                               + lzss_pkg::RUN_W'(lzss_pkg::LEN_BIAS);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && cmd.kind == lzss_pkg::CMD_MATCH) begin
            rd_addr_reg <= cmd.pos;
        end else if (issue) begin
            rd_addr_reg <= rd_addr_reg + 1'b1;
        end
        if (issue) begin
            // byte written this same edge is the one just read: forward it
            e_fwd_reg      <= e_adv && (rd_addr_reg == wp_reg);
            e_fwd_data_reg <= d_cur;
            e_vld_reg      <= rd_in_fill;
            e_last_reg     <= (rem_reg == lzss_pkg::RUN_W'(1));
        end else if (take && cmd.kind == lzss_pkg::CMD_LIT) begin
            e_fwd_reg      <= 1'b1;
            e_fwd_data_reg <= cmd.data;
            e_vld_reg      <= 1'b0;
            e_last_reg     <= 1'b1;
        end
        if (e_adv) begin
            m_byte_reg <= d_cur;
            m_last_reg <= e_last_reg || done_now;
            m_done_reg <= done_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (e_adv) begin
            win_mem[wp_reg] <= d_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= win_mem[rd_addr_reg];
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= lzss_pkg::FILL_W'(lzss_pkg::WIN_DEPTH))
        else $error("fill count beyond window size");

    a_fin_no_run: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> (rem_reg == '0))
        else $error("copy still running after stream end");

    a_done_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (e_adv && done_now && !(take && cmd.clear)) |=> (fin_reg && !e_valid_reg))
        else $error("bytes continue after configured length");

endmodule

`default_nettype wire

/* sv/lzss_stream_decoder_top.sv */
// top level of the lzss stream decoder with a 4096-byte window
`default_nettype none

// usage
//  - s_ channel: one compressed byte per request (s_in_byte), s_new_stream
//    clears the window and counters before that byte is handled
//  - m_ channel: one decompressed byte per request, m_last marks the final
//    byte caused by an input request, m_done_res the byte that reaches the
//    configured length; later input is dropped until s_new_stream
//  - cfg_we/cfg_wdata write the output length, only while the block is idle
//  - flag bytes and first match bytes give no output;
//    the front queues literal and match commands in a two-entry queue
//  - literal: byte passes through the queue, the execute stage and the output
//    register to m_, one literal per cycle sustained while m_ready is high
//  - match of n bytes (3..18): each byte is read from the window into the
//    execute stage, then the output register; one window read and one write
//    a cycle while m_ready is high, no new command until all n are issued
//  - window entries not yet written since the last clear read as zero via
//    a fill count, so there is no clearing pass after reset or new_stream
//  - reset: synchronous on aresetn low, window logically zero, write
//    position 0xFEE, output length one
//  - m_ready low holds the output register; the back end then stalls, the
//    queue fills and s_ready drops

module lzss_stream_decoder_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [lzss_pkg::LEN_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_in_byte,
    input  wire logic                          s_new_stream,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_last,
    output logic                               m_done_res
);

    // front to queue
    logic                 push;
    lzss_pkg::cmd_t       push_cmd;
    logic                 fifo_full;

    // queue to back
    lzss_pkg::cmd_t       pop_cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;

    // parse bytes into commands
    lzss_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_new_stream (s_new_stream),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    // decouples parsing from window copies
    lzss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (cmd_pop),
        .pop_cmd   (pop_cmd),
        .full      (fifo_full),
        .not_empty (cmd_valid)
    );

    // window, copy engine and output register
    lzss_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd        (pop_cmd),
        .cmd_pop    (cmd_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_done_res (m_done_res)
    );

endmodule

`default_nettype wire

/* tb/tb_lzss_stream_decoder_top.sv */
// self-checking testbench for the lzss stream decoder top level
`timescale 1ns / 100ps

module tb_lzss_stream_decoder_top;

    // run limits
    localparam int STUCK_LIMIT  = 4000;   // cycles with no handshake and no config write
    localparam int HOLD_CYCLES  = 400;    // long output hold-off, fills the decoder
    localparam int SETTLE       = 30;     // quiet cycles before a length write
    localparam int DRAIN        = 40;     // quiet cycles at the end
    localparam int ITEM_TARGET  = 280;    // input requests wanted in total
    localparam logic [lzss_pkg::LEN_W-1:0] LEN_MAX = {lzss_pkg::LEN_W{1'b1}};

    // one decompressed byte as seen on the m_ channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } out_beat_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct {
        logic [7:0]                 data;
        logic                       ns;
        logic                       cfg_wr;
        logic [lzss_pkg::LEN_W-1:0] cfg_val;
        logic                       typed;
        int                         n;
        logic [7:0]                 val;
        logic                       fin_done;
    } stim_row_t;

    // clock, reset and block ports
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [lzss_pkg::LEN_W-1:0] cfg_wdata    = '0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [7:0]                 s_in_byte    = 8'h00;
    logic                       s_new_stream = 1'b0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic [7:0]                 m_out_byte;
    logic                       m_last;
    logic                       m_done_res;

    // typed expectation travelling with the request payload
    logic       row_typed    = 1'b0;
    int         row_n        = 0;
    logic [7:0] row_val      = 8'h00;
    logic       row_fin_done = 1'b0;

    // decoder shadow state
    logic [7:0]                 window_bytes [lzss_pkg::WIN_DEPTH];
    logic [11:0]                window_wp;
    logic [8:0]                 flag_bits;
    lzss_pkg::phase_t           dec_phase;
    logic [7:0]                 match_lo;
    logic [lzss_pkg::LEN_W-1:0] produced;
    logic [lzss_pkg::LEN_W-1:0] out_len;
    logic                       finished;

    // bytes still owed by the decoder, oldest first
    out_beat_t pending_bytes [$];

    // bookkeeping
    int  fail_count    = 0;
    int  live_items    = 0;
    int  ignored_items = 0;
    int  bytes_checked = 0;
    int  streams       = 0;
    int  cfg_writes    = 0;
    int  stuck_cycles  = 0;
    bit  burst_mode    = 1'b0;
    bit  hold_off_req  = 1'b0;

    stim_row_t directed_rows [$];

    lzss_stream_decoder_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_new_stream (s_new_stream),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last),
        .m_done_res   (m_done_res)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow decoder
    // ---------------------------------------------------------------

    // window back to zero, write position and counters to their start
    function automatic void clear_history();
        foreach (window_bytes[i]) window_bytes[i] = 8'h00;
        window_wp = lzss_pkg::WP_START;
        flag_bits = '0;
        dec_phase = lzss_pkg::PH_FLAG;
        match_lo  = 8'h00;
        produced  = '0;
        finished  = 1'b0;
    endfunction

    // next token from the remaining flag bits; marker one alone means new flag byte
    function automatic void next_phase();
        if (flag_bits <= 9'd1) begin
            dec_phase = lzss_pkg::PH_FLAG;
        end else begin
            dec_phase = flag_bits[0] ? lzss_pkg::PH_LIT : lzss_pkg::PH_MLOW;
        end
    endfunction

    // write one output byte into the window and owe it on m_; 1 when the stream ends
    function automatic logic emit_byte(input logic [7:0] d);
        out_beat_t b;
        window_bytes[window_wp] = d;
        window_wp = window_wp + 12'd1;
        produced  = produced + 1'b1;
        b.data = d;
        b.last = 1'b0;
        b.done = (produced >= out_len);
        if (b.done) finished = 1'b1;
        pending_bytes.push_back(b);
        return b.done;
    endfunction

    // one compressed byte in, returns how many output bytes it owes
    function automatic int decode_byte(input logic [7:0] b, input logic ns);
        int          first;
        int          run;
        logic [11:0] src;
        first = pending_bytes.size();
        if (ns) clear_history();
        if (finished) return 0;
        case (dec_phase)
            lzss_pkg::PH_FLAG: begin
                flag_bits = {1'b1, b};
                next_phase();
            end
            lzss_pkg::PH_LIT: begin
                void'(emit_byte(b));
                flag_bits = flag_bits >> 1;
                next_phase();
            end
            lzss_pkg::PH_MLOW: begin
                match_lo  = b;
                dec_phase = lzss_pkg::PH_MHIGH;
            end
            default: begin
                // absolute position, each byte read after the previous write
                src = {b[7:4], match_lo};
                run = int'(b[3:0]) + lzss_pkg::LEN_BIAS;
                for (int i = 0; i < run; i++) begin
                    if (emit_byte(window_bytes[src + 12'(i)])) break;
                end
                flag_bits = flag_bits >> 1;
                next_phase();
            end
        endcase
        if (pending_bytes.size() > first) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        return pending_bytes.size() - first;
    endfunction

    // ---------------------------------------------------------------
    // monitor: predicts on input requests, checks output requests
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        int        n;
        out_beat_t want;
        if (aresetn) begin
            // length register follows the write at this edge
            if (cfg_we) out_len = cfg_wdata;

            if (s_valid && s_ready) begin
                if (s_new_stream) streams++;
                if (finished && !s_new_stream) ignored_items++;
                else live_items++;
                n = decode_byte(s_in_byte, s_new_stream);
                // typed table rows replace what the shadow decoder owes
                if (row_typed) begin
                    repeat (n) void'(pending_bytes.pop_back());
                    for (int i = 0; i < row_n; i++) begin
                        want.data = row_val;
                        want.last = (i == row_n - 1);
                        want.done = (i == row_n - 1) && row_fin_done;
                        pending_bytes.push_back(want);
                    end
                end
            end

            if (m_valid && m_ready) begin
                bytes_checked++;
                if (pending_bytes.size() == 0) begin
                    $error("unexpected output byte %02h (last %0b done %0b)",
                           m_out_byte, m_last, m_done_res);
                    fail_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, m_out_byte);
                        fail_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_last);
                        fail_count++;
                    end
                    if (m_done_res !== want.done) begin
                        $error("done_res: expected %0b, got %0b", want.done, m_done_res);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: any handshake or config write counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STUCK_LIMIT);
                $display("FAIL lzss_stream_decoder_top");
                $finish;
            end
        end
    end

    // idle lengths: mostly none or short, a few long, none in burst stretches
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 50);
    endfunction

    // ---------------------------------------------------------------
    // receiver: random m_ready, one long hold-off on request
    // ---------------------------------------------------------------
    initial begin
        int gap;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                // long stall so the decoder backs up into s_ready
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // offer one request after a random gap and wait until it is taken
    task automatic send_item(input logic [7:0] b, input logic ns, input logic typed = 1'b0,
                             input int n = 0, input logic [7:0] val = 8'h00,
                             input logic fin_done = 1'b0);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_in_byte    <= b;
        s_new_stream <= ns;
        row_typed    <= typed;
        row_n        <= n;
        row_val      <= val;
        row_fin_done <= fin_done;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid, wait for every owed byte, then let the decoder settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_length(input logic [lzss_pkg::LEN_W-1:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task automatic add_row(input logic [7:0] data, input logic ns, input logic cfg_wr,
                           input logic [lzss_pkg::LEN_W-1:0] cfg_val, input logic typed,
                           input int n, input logic [7:0] val, input logic fin_done);
        stim_row_t r;
        r.data = data;  r.ns = ns;  r.cfg_wr = cfg_wr;  r.cfg_val = cfg_val;
        r.typed = typed;  r.n = n;  r.val = val;  r.fin_done = fin_done;
        directed_rows.push_back(r);
    endtask

    initial begin
        int                         phase_idx;
        int                         sel;
        int                         groups;
        logic [7:0]                 flags;
        logic [11:0]                src;
        logic [lzss_pkg::LEN_W-1:0] len;

        clear_history();
        out_len = lzss_pkg::LEN_W'(1);

        // ---- directed table ----
        //       byte   ns cfg  value    typed n   val    done
        // length one after reset: first literal ends the stream, rest dropped
        add_row(8'hFF, 0, 0, '0,      1, 0,  8'h00, 0);
        add_row(8'hA5, 0, 0, '0,      1, 1,  8'hA5, 1);
        add_row(8'h3C, 0, 0, '0,      1, 0,  8'h00, 0);
        // longest length, new stream: match, literal, then matches
        add_row(8'h02, 1, 1, LEN_MAX, 1, 0,  8'h00, 0);
        add_row(8'h00, 0, 0, '0,      1, 0,  8'h00, 0);
        add_row(8'h00, 0, 0, '0,      1, 3,  8'h00, 0);   // shortest match, zero window
        add_row(8'hFF, 0, 0, '0,      1, 1,  8'hFF, 0);
        add_row(8'hFF, 0, 0, '0,      1, 0,  8'h00, 0);
        add_row(8'hFF, 0, 0, '0,      1, 18, 8'h00, 0);   // longest match, wraps the window
        add_row(8'hF1, 0, 0, '0,      1, 0,  8'h00, 0);
        add_row(8'hF2, 0, 0, '0,      0, 0,  8'h00, 0);   // picks up the literal
        add_row(8'h04, 0, 0, '0,      1, 0,  8'h00, 0);
        add_row(8'h0F, 0, 0, '0,      0, 0,  8'h00, 0);   // overlapping copy
        // length lowered below the count: next byte ends the match early
        add_row(8'h00, 0, 1, 2,       1, 0,  8'h00, 0);
        add_row(8'h31, 0, 0, '0,      1, 1,  8'h00, 1);
        add_row(8'h77, 0, 0, '0,      1, 0,  8'h00, 0);
        // length reached inside a match
        add_row(8'h01, 1, 1, 4,       1, 0,  8'h00, 0);
        add_row(8'h80, 0, 0, '0,      1, 1,  8'h80, 0);
        add_row(8'h00, 0, 0, '0,      1, 0,  8'h00, 0);
        add_row(8'h0F, 0, 0, '0,      1, 3,  8'h00, 1);
        add_row(8'h55, 0, 0, '0,      1, 0,  8'h00, 0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].cfg_wr) write_length(directed_rows[i].cfg_val);
            send_item(directed_rows[i].data, directed_rows[i].ns, directed_rows[i].typed,
                      directed_rows[i].n, directed_rows[i].val, directed_rows[i].fin_done);
        end

        // ---- random streams: mostly well-formed token groups, some noise ----
        phase_idx = 0;
        while ((live_items + ignored_items) < ITEM_TARGET && phase_idx < 40) begin
            sel = $urandom_range(0, 9);
            if (phase_idx <= 1)  len = LEN_MAX;
            else if (phase_idx == 2) len = lzss_pkg::LEN_W'(1);
            else if (sel == 0) len = LEN_MAX;
            else if (sel == 1) len = lzss_pkg::LEN_W'($urandom_range(1, 8));
            else if (sel < 6)  len = lzss_pkg::LEN_W'($urandom_range(20, 300));
            else len = lzss_pkg::LEN_W'($urandom_range(1, LEN_MAX));
            write_length(len);

            burst_mode = (phase_idx != 1) && ($urandom_range(0, 3) == 0);
            // pressure phase: receiver stalls while requests keep coming
            if (phase_idx == 1) hold_off_req = 1'b1;

            groups = $urandom_range(2, 5);
            for (int g = 0; g < groups && (live_items + ignored_items) < ITEM_TARGET; g++) begin
                flags = 8'($urandom_range(0, 255));
                send_item(flags, g == 0);
                for (int k = 0; k < 8; k++) begin
                    // stray byte, sometimes restarting the stream mid group
                    if ($urandom_range(0, 19) == 0) begin
                        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                    end
                    if (flags[k]) begin
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                    end else begin
                        // half near recent output so copies overlap, half anywhere
                        if ($urandom_range(0, 1) == 0) begin
                            src = window_wp - 12'($urandom_range(1, 24));
                        end else begin
                            src = 12'($urandom_range(0, lzss_pkg::WIN_DEPTH - 1));
                        end
                        send_item(src[7:0], 1'b0);
                        send_item({src[11:8], 4'($urandom_range(0, 15))}, 1'b0);
                    end
                end
            end
            phase_idx++;
        end
        burst_mode = 1'b0;

        // ---- drain and verdict ----
        wait_idle();
        repeat (DRAIN) @(posedge aclk);
        if (pending_bytes.size() != 0) begin
            $error("%0d output bytes never arrived", pending_bytes.size());
            fail_count++;
        end

        $display("covered %0d live and %0d dropped input requests over %0d streams",
                 live_items, ignored_items, streams);
        $display("checked %0d output bytes across %0d length settings", bytes_checked,
                 cfg_writes + 1);
        if (fail_count == 0) begin
            $display("PASS lzss_stream_decoder_top");
        end else begin
            $display("FAIL lzss_stream_decoder_top");
        end
        $finish;
    end

endmodule
